FILE: hdl/ttsc_pkg.sv
`timescale 1ns / 1ps

package ttsc_pkg;

    localparam int WINDOW_LEN_DEF = 16;
    localparam int SAMPLE_W       = 16;
    localparam int LIMIT_W        = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_MUL,
        S_CMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_we;   // write the stability limit
        logic load;     // store the sample, read the oldest entry
        logic sum;      // update the running sums
        logic mul;      // form the products
        logic cmp;      // compare and load the result register
    } t_cmd;

endpackage

FILE: hdl/ttsc_ctrl.sv
`timescale 1ns / 1ps

module ttsc_ctrl
    import ttsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.cfg_we = i_cfg_valid;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                // Wait until the result register is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.cmp   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: hdl/ttsc_dp.sv
`timescale 1ns / 1ps

module ttsc_dp
    import ttsc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_temperature_sample,
    input  logic [LIMIT_W-1:0]         i_cfg_stability_limit,
    output logic                       o_is_stable,
    output logic                       o_became_stable
);

    localparam longint N     = WINDOW_LEN;
    localparam longint ST    = N * (N + 1) / 2;
    localparam longint D     = N * N * (N * N - 1) / 12;
    localparam int     IDX_W = $clog2(WINDOW_LEN);
    localparam int     SX_W  = SAMPLE_W + 1 + $clog2(WINDOW_LEN);
    localparam int     STX_W = SAMPLE_W + 2 + $clog2(ST);
    localparam int     NUM_W = SAMPLE_W + 4 + $clog2(WINDOW_LEN) + $clog2(ST);
    localparam int     LHS_W = NUM_W + 4;
    localparam int     RHS_W = LIMIT_W + $clog2(D + 1) + 1;
    localparam int     CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam logic signed [STX_W-1:0] C_N_STX = STX_W'(N);
    localparam logic signed [NUM_W-1:0] C_N_NUM = NUM_W'(N);
    localparam logic signed [NUM_W-1:0] C_ST    = NUM_W'(ST);
    localparam logic        [RHS_W-1:0] C_D     = RHS_W'(D);

    logic signed [SAMPLE_W-1:0] r_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]      r_vld;
    logic [IDX_W-1:0]           r_pos;
    logic signed [SAMPLE_W-1:0] r_new;
    logic signed [SAMPLE_W-1:0] r_old;
    logic signed [SX_W-1:0]     r_sx;
    logic signed [STX_W-1:0]    r_stx;
    logic signed [NUM_W-1:0]    r_p1;
    logic signed [NUM_W-1:0]    r_p2;
    logic [RHS_W-1:0]           r_rhs;
    logic [LIMIT_W-1:0]         r_limit;
    logic                       r_stable_before;
    logic                       r_is_stable;
    logic                       r_became_stable;

    logic signed [NUM_W-1:0]    n_diff;
    logic [NUM_W-1:0]           n_mag;
    logic [CMP_W-1:0]           n_lhs;
    logic                       n_stable;

    // Window store; entries not yet written read as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_pos] <= i_temperature_sample;
            r_old        <= r_vld[r_pos] ? r_mem[r_pos] : '0;
            r_new        <= i_temperature_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld           <= '0;
            r_pos           <= '0;
            r_sx            <= '0;
            r_stx           <= '0;
            r_limit         <= LIMIT_RESET;
            r_stable_before <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_limit <= i_cfg_stability_limit;
            end
            if (i_cmd.load) begin
                r_vld[r_pos] <= 1'b1;
                r_pos <= (r_pos == IDX_W'(WINDOW_LEN - 1)) ? '0 : r_pos + 1'b1;
            end
            if (i_cmd.sum) begin
                // Every older weight drops by one and the oldest leaves the window.
                r_stx <= r_stx - STX_W'(r_sx) + C_N_STX * STX_W'(r_new);
                r_sx  <= r_sx - SX_W'(r_old) + SX_W'(r_new);
            end
            if (i_cmd.cmp) begin
                r_stable_before <= n_stable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1  <= C_N_NUM * NUM_W'(r_stx);
            r_p2  <= C_ST * NUM_W'(r_sx);
            r_rhs <= RHS_W'(r_limit) * C_D;
        end
        if (i_cmd.cmp) begin
            r_is_stable     <= n_stable;
            r_became_stable <= n_stable && !r_stable_before;
        end
    end

    always_comb begin
        n_diff   = r_p1 - r_p2;
        n_mag    = n_diff[NUM_W-1] ? NUM_W'(-n_diff) : NUM_W'(n_diff);
        n_lhs    = CMP_W'({n_mag, 4'b0000});
        n_stable = n_lhs < CMP_W'(r_rhs);
    end

    assign o_is_stable     = r_is_stable;
    assign o_became_stable = r_became_stable;

endmodule

FILE: hdl/temperature_trend_stability_check_top.sv
`timescale 1ns / 1ps
// A result is offered once an accepted sample has passed through the read, sum,
// product and compare steps, which the controller runs in turn; a new sample is
// taken only after the last one has finished its compare step, and a result still
// waiting holds back the compare step.
// Reset (synchronous, active low) empties the window so that it reads as zeros,
// clears the sums and the stability history, and sets the limit to 256.

module temperature_trend_stability_check_top
    import ttsc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Sample requests.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_temperature_sample,
    // Result requests.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_is_stable,
    output logic                       o_became_stable,
    // Configuration write requests for the stability limit.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [LIMIT_W-1:0]         i_cfg_stability_limit
);

    // The controller sequences each sample through the datapath; the datapath
    // keeps running sums of the window so that only the outgoing sample has to
    // be read back from the store for every new request.
    t_cmd w_cmd;

    ttsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    ttsc_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_temperature_sample  (i_temperature_sample),
        .i_cfg_stability_limit (i_cfg_stability_limit),
        .o_is_stable           (o_is_stable),
        .o_became_stable       (o_became_stable)
    );

endmodule

FILE: dv/temperature_trend_stability_check_top_test.sv
`timescale 1ns / 1ps

module temperature_trend_stability_check_top_test;
    import ttsc_pkg::*;

    // The window length and the slope constants that follow from it. ST is the
    // sum of the sample times 1..N and D is the denominator of the least-squares
    // slope, N^2(N^2-1)/12.
    localparam int     WIN    = WINDOW_LEN_DEF;
    localparam longint WIN_ST = longint'(WIN) * (WIN + 1) / 2;
    localparam longint WIN_D  = longint'(WIN) * WIN * (longint'(WIN) * WIN - 1) / 12;
    localparam int     PHASE_SAMPLES = 250;

    typedef struct packed {
        logic stable;
        logic rise;
    } t_verdict;

    // One pending sample request, with the idle cycles the sender spends
    // before it offers the request.
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        int unsigned                gap;
    } t_sample_req;

    logic                       i_clk;
    logic                       i_rst_n               = 1'b0;
    logic                       i_in_valid            = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_temperature_sample  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready           = 1'b0;
    logic                       o_is_stable;
    logic                       o_became_stable;
    logic                       i_cfg_valid           = 1'b0;
    logic                       o_cfg_ready;
    logic [LIMIT_W-1:0]         i_cfg_stability_limit = '0;

    // Handshakes seen at the last rising edge, for use at the next falling edge.
    bit sample_fire;
    bit verdict_fire;
    bit limit_fire;

    t_sample_req sample_feed_q[$];
    t_verdict    expected_verdicts_q[$];
    int          samples_queued  = 0;
    int          samples_taken   = 0;
    int          mismatch_count  = 0;
    int unsigned idle_max        = 10;
    int          trend_level     = 0;

    // Our own copy of the block's state, kept in step with every accepted request.
    logic signed [SAMPLE_W-1:0] window_model [WIN];
    int                         window_wr_pos = 0;
    logic                       was_stable    = 1'b0;
    logic [LIMIT_W-1:0]         limit_model   = LIMIT_RESET;

    temperature_trend_stability_check_top i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_temperature_sample  (i_temperature_sample),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_is_stable           (o_is_stable),
        .o_became_stable       (o_became_stable),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_stability_limit (i_cfg_stability_limit)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < WIN; k++) begin
            window_model[k] = '0;
        end
    end

    // Writes the new sample into the ring, works out the least-squares slope
    // numerator over the whole window (oldest entry at time 1) and compares it
    // against the limit scaled by D. The zero entries left by reset count as
    // samples until the ring has been filled once.
    function automatic t_verdict advance_window(input logic signed [SAMPLE_W-1:0] x);
        longint   sum_x;
        longint   sum_tx;
        longint   num;
        longint   rhs;
        longint   xv;
        int       idx;
        t_verdict v;
        window_model[window_wr_pos] = x;
        sum_x  = 0;
        sum_tx = 0;
        for (int k = 0; k < WIN; k++) begin
            idx    = (window_wr_pos + 1 + k) % WIN;
            xv     = window_model[idx];
            sum_x  = sum_x + xv;
            sum_tx = sum_tx + xv * (k + 1);
        end
        num = longint'(WIN) * sum_tx - WIN_ST * sum_x;
        if (num < 0) begin
            num = -num;
        end
        // A limit of zero makes the right-hand side zero, so nothing is stable.
        rhs      = longint'(limit_model) * WIN_D;
        v.stable = (num * 16) < rhs;
        v.rise   = v.stable && !was_stable;
        was_stable    = v.stable;
        window_wr_pos = (window_wr_pos + 1) % WIN;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("%0t ns: mismatch on %s: got %b, expected %b", $time, what, got, want);
        mismatch_count++;
    endtask

    // Monitor. Everything is sampled at the rising edge, before the block's own
    // registers move. The limit and the window model are updated exactly when
    // the block accepts the corresponding request.
    always @(posedge i_clk) begin
        sample_fire  <= i_rst_n && i_in_valid && o_in_ready;
        verdict_fire <= i_rst_n && o_out_valid && i_out_ready;
        limit_fire   <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) === 1'b1) begin
                limit_model = i_cfg_stability_limit;
            end
            if ((o_out_valid && i_out_ready) === 1'b1) begin
                if (expected_verdicts_q.size() == 0) begin
                    report_mismatch("result request with nothing outstanding",
                                    o_out_valid, 1'b0);
                end else begin
                    t_verdict want;
                    want = expected_verdicts_q.pop_front();
                    if (o_is_stable !== want.stable) begin
                        report_mismatch("is_stable", o_is_stable, want.stable);
                    end
                    if (o_became_stable !== want.rise) begin
                        report_mismatch("became_stable", o_became_stable, want.rise);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) === 1'b1) begin
                expected_verdicts_q.push_back(advance_window(i_temperature_sample));
                samples_taken++;
            end
        end
    end

    // Sample sender. It moves only at the falling edge, once the previous
    // request has been taken or none is on offer, and honours the idle gap
    // stored with each pending request. Valid is assigned once per step, so a
    // back-to-back request simply keeps it high.
    always @(negedge i_clk) begin : sample_sender
        t_sample_req req;
        int unsigned gap_cnt;
        if (!i_in_valid || sample_fire) begin
            if (sample_feed_q.size() != 0 && gap_cnt >= sample_feed_q[0].gap) begin
                req = sample_feed_q.pop_front();
                i_temperature_sample <= req.value;
                i_in_valid           <= 1'b1;
                gap_cnt = 0;
            end else begin
                i_in_valid <= 1'b0;
                if (sample_feed_q.size() != 0) begin
                    gap_cnt++;
                end
            end
        end
    end

    // Result receiver. After each accepted result it draws a fresh random stall,
    // from zero up to idle_max, during which ready is held low.
    always @(negedge i_clk) begin : result_receiver
        int unsigned result_stall;
        if (verdict_fire) begin
            result_stall = $urandom_range(0, idle_max);
        end
        if (result_stall != 0) begin
            result_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] value);
        t_sample_req req;
        req.value = value;
        req.gap   = $urandom_range(0, idle_max);
        sample_feed_q.push_back(req);
        samples_queued++;
    endtask

    // A run of samples following a straight line with a little noise. The slope
    // is drawn around the point where the limit is crossed, so that the window
    // swings between stable and unstable and the rise pulse is exercised.
    task automatic queue_trend(input logic [LIMIT_W-1:0] lim);
        int span;
        int slope;
        int len;
        int noise;
        int val;
        span = int'(lim) / 16 + 2;
        if (span > 300) begin
            span = 300;
        end
        slope = int'($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(0, 3) == 0) begin
            slope = 0;
        end
        len   = $urandom_range(8, 40);
        noise = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) begin
            trend_level = int'($urandom_range(0, 49151)) - 16384;
        end
        for (int k = 0; k < len; k++) begin
            val = trend_level + slope + int'($urandom_range(0, 2 * noise)) - noise;
            if (val > 32767) begin
                val = 32767;
            end else if (val < -32768) begin
                val = -32768;
            end
            trend_level = val;
            queue_sample(val[SAMPLE_W-1:0]);
        end
    endtask

    task automatic write_stability_limit(input logic [LIMIT_W-1:0] lim);
        @(negedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_stability_limit <= lim;
        do @(negedge i_clk); while (!limit_fire);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued sample has been taken and every result has come
    // back, then lets the pipeline settle before returning.
    task automatic drain_results();
        do @(negedge i_clk);
        while (samples_taken != samples_queued || expected_verdicts_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limit [8];
        int                 phase_start;
        phase_limit[0] = 16'd0;
        phase_limit[1] = 16'd65535;
        phase_limit[2] = 16'd1;
        phase_limit[3] = 16'd16;
        phase_limit[4] = 16'd4096;
        phase_limit[5] = 16'($urandom);
        phase_limit[6] = 16'($urandom_range(0, 1023));
        phase_limit[7] = LIMIT_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset limit. The first few see a window that
        // is still mostly the zeros left by reset; then come the extremes of
        // the sample field, alternating bit patterns, and a flat run that must
        // bring the window back to stable with a single rise pulse.
        queue_sample(16'sd0);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(-16'sd1);
        queue_sample(16'sd1);
        queue_sample(16'sh5555);
        queue_sample(16'shaaaa);
        for (int k = 0; k < WIN; k++) begin
            queue_sample(16'sd100);
        end
        drain_results();

        // Each phase holds the sender back until the previous one has fully
        // drained, so that the limit is only ever written while the block is
        // idle. Alternate phases run without any idling on either side.
        for (int p = 0; p < 8; p++) begin
            idle_max = (p % 2 == 0) ? 10 : 0;
            write_stability_limit(phase_limit[p]);
            phase_start = samples_queued;
            while (samples_queued - phase_start < PHASE_SAMPLES) begin
                if ($urandom_range(0, 99) < 15) begin
                    // A burst of unrelated full-range samples.
                    repeat ($urandom_range(1, 20)) queue_sample(16'($urandom));
                end else begin
                    queue_trend(phase_limit[p]);
                end
            end
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("temperature_trend_stability_check_top_test passed");
        end else begin
            $display("temperature_trend_stability_check_top_test failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("temperature_trend_stability_check_top_test failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/ttsc_pkg.sv
hdl/ttsc_ctrl.sv
hdl/ttsc_dp.sv
hdl/temperature_trend_stability_check_top.sv
dv/temperature_trend_stability_check_top_test.sv
